// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RLFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rlfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rlfp_pkg
// types, codes and constants of the rgb lamp fade and pulse controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlfp_pkg;

    localparam int LEVEL_BITS = 10;
    localparam int RATE_BITS  = 8;

    localparam int MODE_W      = 2;
    localparam int HOUR_W      = 5;
    localparam int FIELD_LVL_W = 10;
    localparam int FIELD_RT_W  = 8;
    localparam int PCT_W       = 7;
    localparam int PHASE_W     = RATE_BITS + 1;
    localparam int HALF_W      = RATE_BITS - 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    typedef logic [LEVEL_BITS-1:0]  level_t;
    typedef logic [RATE_BITS-1:0]   rate_t;
    typedef logic [PHASE_W-1:0]     phase_t;
    typedef logic [HALF_W-1:0]      half_t;
    typedef logic [PCT_W-1:0]       pct_t;
    typedef logic [HOUR_W-1:0]      hour_t;
    typedef logic [FIELD_LVL_W-1:0] drive_t;

    // input modes
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SNAP = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_HOUR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_HOUR    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWEEP_MODE = 2'd2;

    localparam hour_t OFF_HOUR_RST = 5'd0;
    localparam hour_t ON_HOUR_RST  = 5'd7;

    localparam pct_t PCT_FULL  = 7'd100;
    localparam pct_t PCT_FLOOR = 7'd30;

    localparam int SWEEP_LIMIT = 1000;
    localparam int SWEEP_STEP  = 100;

    // x / 100 == (x * RECIP) >> RECIP_SH, exact for x below 2^17
    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = 18;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + 99) / 100);

    localparam int MUL_A_W = LEVEL_BITS + PCT_W;
    localparam int MUL_B_W = RECIP_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        hour_t                  hour_now;
        logic [FIELD_LVL_W-1:0] new_red;
        logic [FIELD_LVL_W-1:0] new_green;
        logic [FIELD_LVL_W-1:0] new_blue;
        logic [FIELD_RT_W-1:0]  new_pulse_rate;
    } in_t;

    typedef struct packed {
        drive_t red_drive;
        drive_t green_drive;
        drive_t blue_drive;
        logic   lamp_active;
        pct_t   brightness;
    } out_t;

    // breathing step 70 / half as a threshold table
    function automatic pct_t breath_step(half_t h);
        int unsigned hv;
        pct_t        s;
        hv = int'(h);
        if (hv <= 1)       s = 7'd70;
        else if (hv == 2)  s = 7'd35;
        else if (hv == 3)  s = 7'd23;
        else if (hv == 4)  s = 7'd17;
        else if (hv == 5)  s = 7'd14;
        else if (hv == 6)  s = 7'd11;
        else if (hv == 7)  s = 7'd10;
        else if (hv == 8)  s = 7'd8;
        else if (hv <= 10) s = 7'd7;
        else if (hv == 11) s = 7'd6;
        else if (hv <= 14) s = 7'd5;
        else if (hv <= 17) s = 7'd4;
        else if (hv <= 23) s = 7'd3;
        else if (hv <= 35) s = 7'd2;
        else if (hv <= 70) s = 7'd1;
        else               s = 7'd0;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgb_led_fade_and_pulse.sv =====
// ----------------------------------------------------------------------------
// rgb_led_fade_and_pulse
// rgb lamp controller: hour window, fade toward goal, sweep, breathing
// ----------------------------------------------------------------------------
// A tick passes through the states in order: ST_IDLE takes the transfer,
// ST_LEVEL moves the three colour levels, ST_SCALE works on the single shared
// multiplier (per colour one pass for level times intensity and one pass times
// the reciprocal of 100), and ST_DONE hands the result to the output register
// and advances the breathing intensity. ST_DONE waits while a previous result
// is still held on the output, and no new tick is taken until it is left.
// Configuration writes are taken at any time and must only be made while idle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rgb_led_fade_and_pulse (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire rlfp_pkg::in_t                   in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output rlfp_pkg::out_t                       out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rlfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rlfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_SCALE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    rlfp_pkg::hour_t off_hour_reg, off_hour_next;
    rlfp_pkg::hour_t on_hour_reg, on_hour_next;
    logic sweep_mode_reg, sweep_mode_next;

    rlfp_pkg::level_t level_reg [3];
    rlfp_pkg::level_t level_next [3];
    rlfp_pkg::level_t goal_reg [3];
    rlfp_pkg::level_t goal_next [3];
    rlfp_pkg::rate_t  pulse_rate_reg, pulse_rate_next;
    rlfp_pkg::phase_t pulse_phase_reg, pulse_phase_next;
    logic             rising_reg, rising_next;
    rlfp_pkg::pct_t   intensity_reg, intensity_next;
    logic             active_reg, active_next;

    rlfp_pkg::in_t    in_q_reg;
    rlfp_pkg::drive_t drv_reg [3];
    rlfp_pkg::out_t   out_q_reg;

    logic in_fire;
    logic out_free;
    logic act;
    rlfp_pkg::level_t nc [3];
    rlfp_pkg::level_t lv [3];
    rlfp_pkg::level_t gl [3];

    logic [rlfp_pkg::MUL_A_W-1:0] mul_a;
    logic [rlfp_pkg::MUL_B_W-1:0] mul_b;
    logic [rlfp_pkg::MUL_P_W-1:0] mul_p;
    rlfp_pkg::drive_t             quot;

    rlfp_pkg::rate_t  br_f;
    rlfp_pkg::half_t  br_half;
    rlfp_pkg::pct_t   br_step;
    logic signed [8:0] br_v;

    function automatic rlfp_pkg::level_t sweep_add(rlfp_pkg::level_t x);
        logic [rlfp_pkg::LEVEL_BITS:0] s;
        s = {1'b0, x} + (rlfp_pkg::LEVEL_BITS + 1)'(rlfp_pkg::SWEEP_STEP);
        // carry out means past the largest level
        return s[rlfp_pkg::LEVEL_BITS] ? '1 : s[rlfp_pkg::LEVEL_BITS-1:0];
    endfunction

    function automatic rlfp_pkg::level_t toward(rlfp_pkg::level_t x, rlfp_pkg::level_t g);
        rlfp_pkg::level_t r;
        if (g > x)      r = x + rlfp_pkg::level_t'(1);
        else if (g < x) r = x - rlfp_pkg::level_t'(1);
        else            r = x;
        return r;
    endfunction

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_q_reg;

    // on window of the stored hour
    always_comb
    begin
        if (off_hour_reg > on_hour_reg)
            act = !(in_q_reg.hour_now > off_hour_reg || in_q_reg.hour_now < on_hour_reg);
        else
            act = !(in_q_reg.hour_now > off_hour_reg && in_q_reg.hour_now < on_hour_reg);
    end

    // level and goal update of one tick
    always_comb
    begin
        nc[0] = rlfp_pkg::level_t'(in_q_reg.new_red);
        nc[1] = rlfp_pkg::level_t'(in_q_reg.new_green);
        nc[2] = rlfp_pkg::level_t'(in_q_reg.new_blue);
        for (int c = 0; c < 3; c++)
        begin
            lv[c] = (in_q_reg.mode == rlfp_pkg::MODE_SNAP) ? nc[c] : level_reg[c];
            gl[c] = (in_q_reg.mode == rlfp_pkg::MODE_SNAP) ? nc[c] : goal_reg[c];
            if (!act)
                gl[c] = '0;
            lv[c] = toward(lv[c], gl[c]);
        end
        // sweep order is red, blue, green
        if (sweep_mode_reg)
        begin
            priority if (int'(lv[0]) < rlfp_pkg::SWEEP_LIMIT)
                lv[0] = sweep_add(lv[0]);
            else if (int'(lv[2]) < rlfp_pkg::SWEEP_LIMIT)
                lv[2] = sweep_add(lv[2]);
            else if (int'(lv[1]) < rlfp_pkg::SWEEP_LIMIT)
                lv[1] = sweep_add(lv[1]);
            else
            begin
                lv[0] = '0;
                lv[1] = '0;
                lv[2] = '0;
            end
        end
        // goals loaded after the step take effect next tick
        if (in_q_reg.mode == rlfp_pkg::MODE_LOAD && act)
        begin
            for (int c = 0; c < 3; c++)
                gl[c] = nc[c];
        end
    end

    // operand select of the shared multiplier
    always_comb
    begin
        unique case (cnt_reg)
            3'd0:
            begin
                mul_a = rlfp_pkg::MUL_A_W'(level_reg[0]);
                mul_b = rlfp_pkg::MUL_B_W'(intensity_reg);
            end
            3'd2:
            begin
                mul_a = rlfp_pkg::MUL_A_W'(level_reg[1]);
                mul_b = rlfp_pkg::MUL_B_W'(intensity_reg);
            end
            3'd4:
            begin
                mul_a = rlfp_pkg::MUL_A_W'(level_reg[2]);
                mul_b = rlfp_pkg::MUL_B_W'(intensity_reg);
            end
            default:
            begin
                mul_a = mul_p[rlfp_pkg::MUL_A_W-1:0];
                mul_b = rlfp_pkg::RECIP;
            end
        endcase
    end

    rlfp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign quot = rlfp_pkg::drive_t'(mul_p[rlfp_pkg::RECIP_SH +: rlfp_pkg::LEVEL_BITS]);

    // breathing step terms
    always_comb
    begin
        br_f    = (pulse_rate_reg == rlfp_pkg::rate_t'(1)) ? rlfp_pkg::rate_t'(2) : pulse_rate_reg;
        br_half = br_f[rlfp_pkg::RATE_BITS-1:1];
        br_step = rlfp_pkg::breath_step(br_half);
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        off_hour_next    = off_hour_reg;
        on_hour_next     = on_hour_reg;
        sweep_mode_next  = sweep_mode_reg;
        level_next       = level_reg;
        goal_next        = goal_reg;
        pulse_rate_next  = pulse_rate_reg;
        pulse_phase_next = pulse_phase_reg;
        rising_next      = rising_reg;
        intensity_next   = intensity_reg;
        active_next      = active_reg;
        br_v             = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rlfp_pkg::CFG_OFF_HOUR:   off_hour_next   = cfg_data;
                rlfp_pkg::CFG_ON_HOUR:    on_hour_next    = cfg_data;
                rlfp_pkg::CFG_SWEEP_MODE: sweep_mode_next = cfg_data[0];
                default:                  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                level_next  = lv;
                goal_next   = gl;
                active_next = act;
                if (in_q_reg.mode == rlfp_pkg::MODE_SNAP ||
                    (in_q_reg.mode == rlfp_pkg::MODE_LOAD && act))
                    pulse_rate_next = rlfp_pkg::rate_t'(in_q_reg.new_pulse_rate);
                cnt_next   = '0;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (pulse_rate_reg == '0)
                    begin
                        intensity_next   = rlfp_pkg::PCT_FULL;
                        pulse_phase_next = '0;
                        rising_next      = 1'b0;
                    end
                    else
                    begin
                        if (!rising_reg)
                        begin
                            br_v = $signed({2'b00, intensity_reg}) - $signed({2'b00, br_step});
                            if (pulse_phase_reg > rlfp_pkg::phase_t'(br_half))
                                rising_next = 1'b1;
                            pulse_phase_next = pulse_phase_reg + rlfp_pkg::phase_t'(1);
                        end
                        else
                        begin
                            br_v = $signed({2'b00, intensity_reg}) + $signed({2'b00, br_step});
                            pulse_phase_next = pulse_phase_reg + rlfp_pkg::phase_t'(1);
                            // end of a breath restarts from full light
                            if (pulse_phase_reg > rlfp_pkg::phase_t'(br_f))
                            begin
                                rising_next      = 1'b0;
                                pulse_phase_next = rlfp_pkg::phase_t'(1);
                                br_v             = $signed({2'b00, rlfp_pkg::PCT_FULL});
                            end
                        end
                        priority if (br_v > $signed({2'b00, rlfp_pkg::PCT_FULL}))
                            intensity_next = rlfp_pkg::PCT_FULL;
                        else if (br_v < $signed({2'b00, rlfp_pkg::PCT_FLOOR}))
                            intensity_next = rlfp_pkg::PCT_FLOOR;
                        else
                            intensity_next = br_v[rlfp_pkg::PCT_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            off_hour_reg    <= rlfp_pkg::OFF_HOUR_RST;
            on_hour_reg     <= rlfp_pkg::ON_HOUR_RST;
            sweep_mode_reg  <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                level_reg[c] <= '0;
                goal_reg[c]  <= '0;
            end
            pulse_rate_reg  <= '0;
            pulse_phase_reg <= '0;
            rising_reg      <= 1'b0;
            intensity_reg   <= rlfp_pkg::PCT_FULL;
            active_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            off_hour_reg    <= off_hour_next;
            on_hour_reg     <= on_hour_next;
            sweep_mode_reg  <= sweep_mode_next;
            level_reg       <= level_next;
            goal_reg        <= goal_next;
            pulse_rate_reg  <= pulse_rate_next;
            pulse_phase_reg <= pulse_phase_next;
            rising_reg      <= rising_next;
            intensity_reg   <= intensity_next;
            active_reg      <= active_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_q_reg <= in_data;
        if (state_reg == ST_SCALE)
        begin
            // quotient of colour n is taken once its reciprocal pass is registered
            if (cnt_reg == 3'd2)
                drv_reg[0] <= quot;
            if (cnt_reg == 3'd4)
                drv_reg[1] <= quot;
            if (cnt_reg == 3'd6)
                drv_reg[2] <= quot;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_q_reg.red_drive   <= drv_reg[0];
            out_q_reg.green_drive <= drv_reg[1];
            out_q_reg.blue_drive  <= drv_reg[2];
            out_q_reg.lamp_active <= active_reg;
            out_q_reg.brightness  <= intensity_reg;
        end
    end

    `RLFP_ASSERT_IMP(a_bright_range, out_valid,
        (out_data.brightness >= rlfp_pkg::PCT_FLOOR) && (out_data.brightness <= rlfp_pkg::PCT_FULL),
        "brightness outside 30..100")
    `RLFP_ASSERT_IMP(a_intensity_range, 1'b1,
        (intensity_reg >= rlfp_pkg::PCT_FLOOR) && (intensity_reg <= rlfp_pkg::PCT_FULL),
        "intensity outside 30..100")
    `RLFP_ASSERT_NXT(a_busy_after_take, in_fire, !in_ready,
        "input taken while a tick is in progress")
    `RLFP_ASSERT_IMP(a_rise_needs_rate, (state_reg == ST_IDLE) && rising_reg,
        pulse_rate_reg != '0, "rising phase with steady light")
    `RLFP_ASSERT_NXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_data),
        "pending result changed before its transfer")

endmodule

`default_nettype wire

// ===== rtl/core/rlfp_mul.sv =====
// ----------------------------------------------------------------------------
// rlfp_mul
// shared multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlfp_mul (
    input  wire logic                        clk,
    input  wire logic [rlfp_pkg::MUL_A_W-1:0] a,
    input  wire logic [rlfp_pkg::MUL_B_W-1:0] b,
    output logic      [rlfp_pkg::MUL_P_W-1:0] p
);

    logic [rlfp_pkg::MUL_P_W-1:0] p_reg;
    logic [rlfp_pkg::MUL_P_W-1:0] p_next;

    assign p_next = rlfp_pkg::MUL_P_W'(a) * rlfp_pkg::MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== tb/sv/rgb_led_fade_and_pulse_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_fade_and_pulse_tb
// Self-checking bench for the rgb lamp controller. Every tick transfer is run
// through a local model of the hour window, colour fade, sweep and breathing
// intensity, and each result transfer is checked field by field in order.
// A few directed ticks come first, then phases of random tick runs under
// changing register settings, most of them with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module rgb_led_fade_and_pulse_tb;

    localparam logic [rlfp_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int LEVEL_MAX   = (1 << rlfp_pkg::LEVEL_BITS) - 1;
    localparam int BREATH_SPAN = 70;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    rlfp_pkg::in_t  in_data = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    rlfp_pkg::out_t out_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [rlfp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rlfp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // model of the lamp state and its registers
    rlfp_pkg::hour_t  off_hour_q = rlfp_pkg::OFF_HOUR_RST;
    rlfp_pkg::hour_t  on_hour_q = rlfp_pkg::ON_HOUR_RST;
    logic             sweep_q = 1'b0;
    rlfp_pkg::level_t lvl_r = '0, lvl_g = '0, lvl_b = '0;
    rlfp_pkg::level_t goal_r = '0, goal_g = '0, goal_b = '0;
    rlfp_pkg::rate_t  rate_q = '0;
    rlfp_pkg::phase_t phase_q = '0;
    logic             rising_q = 1'b0;
    rlfp_pkg::pct_t   pct_q = rlfp_pkg::PCT_FULL;

    rlfp_pkg::out_t lamp_out_q[$];
    int   mismatch_count = 0;
    bit   idling = 1'b1;
    int   stall_left = 0;

    always #4 clk = ~clk;

    rgb_led_fade_and_pulse uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic rlfp_pkg::level_t step_toward(rlfp_pkg::level_t lvl,
                                                     rlfp_pkg::level_t goal);
        if (goal > lvl)
            return lvl + 1'b1;
        if (goal < lvl)
            return lvl - 1'b1;
        return lvl;
    endfunction

    function automatic rlfp_pkg::level_t sweep_add(rlfp_pkg::level_t lvl);
        int s;
        s = int'(lvl) + rlfp_pkg::SWEEP_STEP;
        return (s > LEVEL_MAX) ? rlfp_pkg::level_t'(LEVEL_MAX) : rlfp_pkg::level_t'(s);
    endfunction

    function automatic rlfp_pkg::drive_t scale_level(rlfp_pkg::level_t lvl,
                                                     rlfp_pkg::pct_t pct);
        return rlfp_pkg::drive_t'((int'(lvl) * int'(pct)) / int'(rlfp_pkg::PCT_FULL));
    endfunction

    // one tick of the lamp: returns the drive values and advances the state
    function automatic rlfp_pkg::out_t lamp_tick(rlfp_pkg::in_t t);
        rlfp_pkg::out_t res;
        logic active;
        int   v, f, half, stp;
        if (off_hour_q > on_hour_q)
            active = !(t.hour_now > off_hour_q || t.hour_now < on_hour_q);
        else
            active = !(t.hour_now > off_hour_q && t.hour_now < on_hour_q);

        if (t.mode == rlfp_pkg::MODE_SNAP)
        begin
            lvl_r = t.new_red;
            lvl_g = t.new_green;
            lvl_b = t.new_blue;
            goal_r = t.new_red;
            goal_g = t.new_green;
            goal_b = t.new_blue;
            rate_q = t.new_pulse_rate;
        end
        if (!active)
        begin
            goal_r = '0;
            goal_g = '0;
            goal_b = '0;
        end

        lvl_r = step_toward(lvl_r, goal_r);
        lvl_g = step_toward(lvl_g, goal_g);
        lvl_b = step_toward(lvl_b, goal_b);

        if (sweep_q)
        begin
            if (lvl_r < rlfp_pkg::SWEEP_LIMIT)
                lvl_r = sweep_add(lvl_r);
            else if (lvl_b < rlfp_pkg::SWEEP_LIMIT)
                lvl_b = sweep_add(lvl_b);
            else if (lvl_g < rlfp_pkg::SWEEP_LIMIT)
                lvl_g = sweep_add(lvl_g);
            else
            begin
                lvl_r = '0;
                lvl_g = '0;
                lvl_b = '0;
            end
        end

        res.red_drive = scale_level(lvl_r, pct_q);
        res.green_drive = scale_level(lvl_g, pct_q);
        res.blue_drive = scale_level(lvl_b, pct_q);
        res.lamp_active = active;
        res.brightness = pct_q;

        // goals loaded after the drives are computed, only inside the window
        if (t.mode == rlfp_pkg::MODE_LOAD && active)
        begin
            goal_r = t.new_red;
            goal_g = t.new_green;
            goal_b = t.new_blue;
            rate_q = t.new_pulse_rate;
        end

        if (rate_q == '0)
        begin
            pct_q = rlfp_pkg::PCT_FULL;
            phase_q = '0;
            rising_q = 1'b0;
        end
        else
        begin
            // rate 1 would give a zero half period
            f = (rate_q == 1) ? 2 : int'(rate_q);
            half = f / 2;
            stp = BREATH_SPAN / half;
            v = int'(pct_q);
            if (!rising_q)
            begin
                v = v - stp;
                if (int'(phase_q) > half)
                    rising_q = 1'b1;
            end
            else
            begin
                v = v + stp;
                if (int'(phase_q) > f)
                begin
                    rising_q = 1'b0;
                    phase_q = '0;
                    v = int'(rlfp_pkg::PCT_FULL);
                end
            end
            if (v > int'(rlfp_pkg::PCT_FULL))
                v = int'(rlfp_pkg::PCT_FULL);
            if (v < int'(rlfp_pkg::PCT_FLOOR))
                v = int'(rlfp_pkg::PCT_FLOOR);
            pct_q = rlfp_pkg::pct_t'(v);
            phase_q = phase_q + 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        rlfp_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lamp_out_q.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = lamp_out_q.pop_front();
                check_field("red_drive", out_data.red_drive, want.red_drive);
                check_field("green_drive", out_data.green_drive, want.green_drive);
                check_field("blue_drive", out_data.blue_drive, want.blue_drive);
                check_field("lamp_active", out_data.lamp_active, want.lamp_active);
                check_field("brightness", out_data.brightness, want.brightness);
            end
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic rlfp_pkg::in_t make_tick(logic [rlfp_pkg::MODE_W-1:0] m,
                                                rlfp_pkg::hour_t h,
                                                rlfp_pkg::level_t r,
                                                rlfp_pkg::level_t g,
                                                rlfp_pkg::level_t b,
                                                rlfp_pkg::rate_t p);
        rlfp_pkg::in_t t;
        t.mode = m;
        t.hour_now = h;
        t.new_red = r;
        t.new_green = g;
        t.new_blue = b;
        t.new_pulse_rate = p;
        return t;
    endfunction

    task automatic send_tick(rlfp_pkg::in_t t);
        @(negedge clk);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lamp_out_q.push_back(lamp_tick(t));
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (lamp_out_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [rlfp_pkg::CFG_INDEX_W-1:0] idx,
                             logic [rlfp_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rlfp_pkg::CFG_OFF_HOUR:   off_hour_q = val;
            rlfp_pkg::CFG_ON_HOUR:    on_hour_q = val;
            rlfp_pkg::CFG_SWEEP_MODE: sweep_q = val[0];
            default:                  ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers only change once every pending result is out
    task automatic set_lamp_config(int off_h, int on_h, int sweep);
        drain();
        write_reg(rlfp_pkg::CFG_OFF_HOUR, rlfp_pkg::CFG_DATA_W'(off_h));
        write_reg(rlfp_pkg::CFG_ON_HOUR, rlfp_pkg::CFG_DATA_W'(on_h));
        write_reg(rlfp_pkg::CFG_SWEEP_MODE, rlfp_pkg::CFG_DATA_W'(sweep));
    endtask

    function automatic rlfp_pkg::level_t rand_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return rlfp_pkg::level_t'(LEVEL_MAX);
            default: return rlfp_pkg::level_t'($urandom_range(0, LEVEL_MAX));
        endcase
    endfunction

    // reset settings: window closed for hours 1..6
    task automatic test_modes_and_extremes;
        send_tick(make_tick(rlfp_pkg::MODE_SNAP, 12, 1023, 1023, 1023, 0));
        send_tick(make_tick(rlfp_pkg::MODE_TICK, 12, 0, 0, 0, 0));
        send_tick(make_tick(rlfp_pkg::MODE_LOAD, 12, 0, 1023, 512, 255));
        send_tick(make_tick(MODE_SPARE, 31, 1023, 1023, 1023, 255));
        // load attempt outside the window is dropped
        send_tick(make_tick(rlfp_pkg::MODE_LOAD, 3, 1023, 1023, 1023, 5));
        send_tick(make_tick(rlfp_pkg::MODE_TICK, 0, 0, 0, 0, 0));
        // rate 1 breathes like rate 2
        send_tick(make_tick(rlfp_pkg::MODE_SNAP, 23, 0, 0, 0, 1));
        repeat (3)
            send_tick(make_tick(rlfp_pkg::MODE_TICK, 23, 0, 0, 0, 0));
    endtask

    task automatic test_hour_window;
        // window open from 6 to 22, closed hours wrap past midnight
        set_lamp_config(22, 6, 0);
        send_tick(make_tick(rlfp_pkg::MODE_SNAP, 5, 700, 300, 900, 4));
        send_tick(make_tick(rlfp_pkg::MODE_LOAD, 6, 700, 300, 900, 4));
        send_tick(make_tick(rlfp_pkg::MODE_TICK, 22, 0, 0, 0, 0));
        send_tick(make_tick(rlfp_pkg::MODE_TICK, 23, 0, 0, 0, 0));
        send_tick(make_tick(rlfp_pkg::MODE_TICK, 31, 0, 0, 0, 0));
        // equal hours keep the window always open
        set_lamp_config(10, 10, 0);
        send_tick(make_tick(rlfp_pkg::MODE_LOAD, 9, 100, 200, 300, 0));
        send_tick(make_tick(rlfp_pkg::MODE_TICK, 10, 0, 0, 0, 0));
        send_tick(make_tick(rlfp_pkg::MODE_TICK, 31, 0, 0, 0, 0));
    endtask

    task automatic test_colour_sweep;
        set_lamp_config(0, 7, 1);
        // red saturates at full scale, then blue, then green
        send_tick(make_tick(rlfp_pkg::MODE_SNAP, 12, 995, 995, 995, 0));
        repeat (3)
            send_tick(make_tick(rlfp_pkg::MODE_TICK, 12, 0, 0, 0, 0));
        send_tick(make_tick(rlfp_pkg::MODE_SNAP, 12, 1000, 500, 0, 0));
        // all levels past the sweep limit wrap to black
        send_tick(make_tick(rlfp_pkg::MODE_SNAP, 12, 1023, 1023, 1023, 0));
    endtask

    // runs of ticks at one hour, usually opened by a snap or a load
    task automatic run_random_ticks(int n);
        int    sent, run_len, k, sel;
        rlfp_pkg::hour_t h;
        logic [rlfp_pkg::MODE_W-1:0] m;
        rlfp_pkg::rate_t p;
        sent = 0;
        while (sent < n)
        begin
            h = ($urandom_range(0, 9) == 0) ? rlfp_pkg::hour_t'($urandom_range(24, 31))
                                            : rlfp_pkg::hour_t'($urandom_range(0, 23));
            run_len = $urandom_range(1, 24);
            for (k = 0; k < run_len && sent < n; k++)
            begin
                sel = $urandom_range(0, 19);
                if (k == 0)
                    m = (sel < 8) ? rlfp_pkg::MODE_SNAP
                      : (sel < 16) ? rlfp_pkg::MODE_LOAD : rlfp_pkg::MODE_TICK;
                else
                    m = (sel < 2) ? rlfp_pkg::MODE_LOAD : (sel == 2) ? rlfp_pkg::MODE_SNAP
                      : (sel == 3) ? MODE_SPARE : rlfp_pkg::MODE_TICK;
                case ($urandom_range(0, 9))
                    0, 1:    p = '0;
                    2, 3:    p = rlfp_pkg::rate_t'($urandom_range(0, 255));
                    default: p = rlfp_pkg::rate_t'($urandom_range(1, 12));
                endcase
                send_tick(make_tick(m, h, rand_level(), rand_level(), rand_level(), p));
                sent++;
            end
        end
    endtask

    task automatic test_random_settings;
        int ph, off_h, on_h;
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:       begin off_h = 0;  on_h = 0;  end
                1:       begin off_h = 23; on_h = 23; end
                2:       begin off_h = 23; on_h = 0;  end
                3:       begin off_h = 0;  on_h = 23; end
                4:       begin off_h = 31; on_h = $urandom_range(0, 23); end
                default:
                begin
                    off_h = $urandom_range(0, 23);
                    on_h = $urandom_range(0, 23);
                end
            endcase
            set_lamp_config(off_h, on_h, (ph % 2 == 1) ? 1 : $urandom_range(0, 1));
            idling = (ph % 3 != 2);
            run_random_ticks(160);
        end
    endtask

    task automatic test_random_no_idle;
        set_lamp_config($urandom_range(12, 23), $urandom_range(0, 11), 0);
        idling = 1'b0;
        run_random_ticks(160);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_modes_and_extremes();
        test_hour_window();
        test_colour_sweep();
        test_random_settings();
        test_random_no_idle();
        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("rgb_led_fade_and_pulse regression: pass");
        else
            $display("rgb_led_fade_and_pulse regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("rgb_led_fade_and_pulse regression: fail");
        $finish;
    end

endmodule
